@@ design/planar_pose_euler_integrator_macros.svh @@
// Assertion macros for the planar pose integrator.
// Used by the top level; expects aclk and aresetn in scope.
`ifndef PLANAR_POSE_EULER_INTEGRATOR_MACROS_SVH
`define PLANAR_POSE_EULER_INTEGRATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PPEI_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PPEI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/ppei_pkg.sv @@
// Shared types and constants for the planar pose integrator.
// Holds the control word layout, the microprogram ROM and the CORDIC arctangent table.
package ppei_pkg;

    localparam int CORDIC_ITERS = 24;
    localparam int ITER_W       = 5;
    localparam int PC_W         = 4;

    localparam logic signed [31:0] CORDIC_X0   = 32'sd652032874;
    // round(2^32 / (2*pi)): radians to 32-bit turn fraction
    localparam logic signed [32:0] TURN_TO_BAM = 33'sd683565276;
    localparam logic [15:0]        STEP_RESET  = 16'd655;

    // register index on the config port (paddr[2])
    localparam logic REG_STEP_TIME = 1'b0;

    // microprogram step labels
    localparam logic [PC_W-1:0] PC_IDLE     = 4'd0;
    localparam logic [PC_W-1:0] PC_MUL_VX   = 4'd1;
    localparam logic [PC_W-1:0] PC_MUL_VY   = 4'd2;
    localparam logic [PC_W-1:0] PC_MUL_W    = 4'd3;
    localparam logic [PC_W-1:0] PC_ROT_LOOP = 4'd4;
    localparam logic [PC_W-1:0] PC_FLIP     = 4'd5;
    localparam logic [PC_W-1:0] PC_AC       = 4'd6;
    localparam logic [PC_W-1:0] PC_BS       = 4'd7;
    localparam logic [PC_W-1:0] PC_AS       = 4'd8;
    localparam logic [PC_W-1:0] PC_BC       = 4'd9;
    localparam logic [PC_W-1:0] PC_SUM_Y    = 4'd10;
    localparam logic [PC_W-1:0] PC_WAIT_OUT = 4'd11;
    localparam logic [PC_W-1:0] PC_WRITE    = 4'd12;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_VX_ST,
        MUL_VY_ST,
        MUL_WR_ST,
        MUL_W_K,
        MUL_A_CX,
        MUL_B_CY,
        MUL_A_CY,
        MUL_B_CX
    } mul_sel_t;

    typedef enum logic [2:0] {
        DST_NONE,
        DST_A,
        DST_B,
        DST_W,
        DST_DH,
        DST_ACC_SET,
        DST_ACC_SUB,
        DST_ACC_ADD
    } dst_sel_t;

    typedef enum logic [1:0] {
        ROT_NONE,
        ROT_INIT,
        ROT_ITER,
        ROT_FLIP
    } rot_op_t;

    typedef enum logic [1:0] {
        POS_NONE,
        POS_UPD_X,
        POS_UPD_Y_OUT
    } pos_op_t;

    typedef enum logic [2:0] {
        COND_NONE,
        COND_NOT_ACCEPT,
        COND_ITER_MORE,
        COND_OUT_BUSY,
        COND_ALWAYS
    } cond_t;

    typedef struct packed {
        logic            in_ready;
        mul_sel_t        mul_sel;
        dst_sel_t        dst_sel;
        rot_op_t         rot_op;
        pos_op_t         pos_op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ctrl_t;

    typedef struct packed {
        logic accept;
        logic iter_more;
        logic out_busy;
    } useq_status_t;

    function automatic logic signed [31:0] atan_lut(input logic [ITER_W-1:0] idx);
        logic signed [31:0] v;
        case (idx)
            5'd0:    v = 32'sd536870912;
            5'd1:    v = 32'sd316933406;
            5'd2:    v = 32'sd167458907;
            5'd3:    v = 32'sd85004756;
            5'd4:    v = 32'sd42667331;
            5'd5:    v = 32'sd21354465;
            5'd6:    v = 32'sd10679838;
            5'd7:    v = 32'sd5340245;
            5'd8:    v = 32'sd2670163;
            5'd9:    v = 32'sd1335087;
            5'd10:   v = 32'sd667544;
            5'd11:   v = 32'sd333772;
            5'd12:   v = 32'sd166886;
            5'd13:   v = 32'sd83443;
            5'd14:   v = 32'sd41722;
            5'd15:   v = 32'sd20861;
            5'd16:   v = 32'sd10430;
            5'd17:   v = 32'sd5215;
            5'd18:   v = 32'sd2608;
            5'd19:   v = 32'sd1304;
            5'd20:   v = 32'sd652;
            5'd21:   v = 32'sd326;
            5'd22:   v = 32'sd163;
            5'd23:   v = 32'sd81;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    // Microprogram: one control word per step.
    function automatic ctrl_t ucode_rom(input logic [PC_W-1:0] pc);
        ctrl_t w;
        w          = '0;
        w.mul_sel  = MUL_NONE;
        w.dst_sel  = DST_NONE;
        w.rot_op   = ROT_NONE;
        w.pos_op   = POS_NONE;
        w.cond     = COND_NONE;
        w.target   = PC_IDLE;
        case (pc)
            PC_IDLE: begin
                w.in_ready = 1'b1;
                w.rot_op   = ROT_INIT;
                w.cond     = COND_NOT_ACCEPT;
                w.target   = PC_IDLE;
            end
            PC_MUL_VX: begin
                w.mul_sel = MUL_VX_ST;
                w.rot_op  = ROT_ITER;
            end
            PC_MUL_VY: begin
                w.mul_sel = MUL_VY_ST;
                w.dst_sel = DST_A;
                w.rot_op  = ROT_ITER;
            end
            PC_MUL_W: begin
                w.mul_sel = MUL_WR_ST;
                w.dst_sel = DST_B;
                w.rot_op  = ROT_ITER;
            end
            PC_ROT_LOOP: begin
                w.dst_sel = DST_W;
                w.rot_op  = ROT_ITER;
                w.cond    = COND_ITER_MORE;
                w.target  = PC_ROT_LOOP;
            end
            PC_FLIP: begin
                w.mul_sel = MUL_W_K;
                w.rot_op  = ROT_FLIP;
            end
            PC_AC: begin
                w.mul_sel = MUL_A_CX;
                w.dst_sel = DST_DH;
            end
            PC_BS: begin
                w.mul_sel = MUL_B_CY;
                w.dst_sel = DST_ACC_SET;
            end
            PC_AS: begin
                w.mul_sel = MUL_A_CY;
                w.dst_sel = DST_ACC_SUB;
            end
            PC_BC: begin
                w.mul_sel = MUL_B_CX;
                w.dst_sel = DST_ACC_SET;
                w.pos_op  = POS_UPD_X;
            end
            PC_SUM_Y: begin
                w.dst_sel = DST_ACC_ADD;
            end
            PC_WAIT_OUT: begin
                w.cond   = COND_OUT_BUSY;
                w.target = PC_WAIT_OUT;
            end
            PC_WRITE: begin
                w.pos_op = POS_UPD_Y_OUT;
                w.cond   = COND_ALWAYS;
                w.target = PC_IDLE;
            end
            default: begin
                w.cond   = COND_ALWAYS;
                w.target = PC_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

@@ design/planar_pose_euler_integrator.sv @@
// Planar pose integrator: top level with config port, handshakes and datapath.
// Depends on ppei_pkg, ppei_useq and planar_pose_euler_integrator_macros.svh.
//
// Each velocity command (vel_x, vel_y, yaw_rate, Q8.8) advances the pose by one Euler
// step of step_time seconds (Q0.16, reset 655). The body velocity is rotated by the old
// heading (24-step CORDIC), then the heading advances by yaw_rate*step_time and wraps;
// positions are Q16.16 and saturate. The CORDIC rotation runs one iteration per cycle, and
// eight multiply and accumulate steps share a single 33x33 multiplier. The next command is
// taken as soon as the sequencer returns to idle, even while the last result still waits
// in the output register. step_time is written over an APB port at byte address 0.
`include "planar_pose_euler_integrator_macros.svh"

module planar_pose_euler_integrator #(
    parameter int ANGLE_BITS = 16,
    parameter int POS_BITS   = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    // config port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // velocity command
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_vel_x,
    input  logic signed [15:0] s_vel_y,
    input  logic signed [15:0] s_yaw_rate,
    // pose result
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_pos_x,
    output logic signed [31:0] m_pos_y,
    output logic [15:0]        m_heading
);
    import ppei_pkg::*;

    localparam int SUM_W = ((POS_BITS > 26) ? POS_BITS : 26) + 1;
    localparam int OUT_W = (POS_BITS > 32) ? POS_BITS : 32;
    localparam logic signed [SUM_W-1:0] PMAX = SUM_W'((64'sd1 <<< (POS_BITS - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] PMIN = -PMAX - SUM_W'(1);
    localparam logic signed [OUT_W-1:0] OMAX = OUT_W'(64'sd2147483647);
    localparam logic signed [OUT_W-1:0] OMIN = OUT_W'(-64'sd2147483648);
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_ITERS - 1);

    function automatic logic signed [31:0] clamp32(input logic signed [POS_BITS-1:0] p);
        logic signed [OUT_W-1:0] e;
        logic signed [OUT_W-1:0] r;
        e = OUT_W'(p);
        if (e > OMAX) begin
            r = OMAX;
        end else if (e < OMIN) begin
            r = OMIN;
        end else begin
            r = e;
        end
        return r[31:0];
    endfunction

    // rescale the binary angle to 16 bits
    function automatic logic [15:0] hdg16(input logic [ANGLE_BITS-1:0] h);
        logic [ANGLE_BITS+15:0] t;
        t = {h, 16'b0} >> ANGLE_BITS;
        return t[15:0];
    endfunction

    ctrl_t        ctrl;
    useq_status_t status;

    logic        s_fire;
    logic        out_busy;

    logic [15:0] step_time_reg;

    logic signed [15:0] vx_reg;
    logic signed [15:0] vy_reg;
    logic signed [15:0] wr_reg;
    logic signed [31:0] a_reg;
    logic signed [31:0] b_reg;
    logic signed [31:0] w_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] acc_reg;
    logic [ANGLE_BITS-1:0] dh_reg;

    logic signed [31:0] cx_reg;
    logic signed [31:0] cy_reg;
    logic signed [31:0] cz_reg;
    logic               flip_reg;
    logic [ITER_W-1:0]  it_reg;

    logic signed [POS_BITS-1:0] pos_x_reg;
    logic signed [POS_BITS-1:0] pos_y_reg;
    logic [ANGLE_BITS-1:0]      head_reg;

    logic               m_valid_reg;
    logic signed [31:0] m_pos_x_reg;
    logic signed [31:0] m_pos_y_reg;
    logic [15:0]        m_heading_reg;

    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] prod_full;

    logic [31:0]        ang;
    logic               ang_flip;
    logic signed [31:0] xs;
    logic signed [31:0] ys;
    logic signed [31:0] atan_v;

    logic signed [63:0]         acc_rnd;
    logic signed [25:0]         dpos;
    logic signed [POS_BITS-1:0] pos_sel;
    logic signed [SUM_W-1:0]    pos_sum;
    logic signed [POS_BITS-1:0] pos_new;
    logic signed [63:0]         dh_rnd;
    logic [ANGLE_BITS-1:0]      head_next;

    ppei_useq u_useq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    assign s_ready  = ctrl.in_ready;
    assign s_fire   = s_valid && s_ready;
    assign out_busy = m_valid_reg && !m_ready;

    assign status.accept    = s_fire;
    assign status.iter_more = (it_reg != ITER_LAST);
    assign status.out_busy  = out_busy;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_STEP_TIME) ? {16'b0, step_time_reg} : 32'b0;

    assign m_valid   = m_valid_reg;
    assign m_pos_x   = m_pos_x_reg;
    assign m_pos_y   = m_pos_y_reg;
    assign m_heading = m_heading_reg;

    // shared multiplier operand select
    always_comb begin
        case (ctrl.mul_sel)
            MUL_VX_ST: begin
                mul_a = 33'(vx_reg);
                mul_b = $signed({17'b0, step_time_reg});
            end
            MUL_VY_ST: begin
                mul_a = 33'(vy_reg);
                mul_b = $signed({17'b0, step_time_reg});
            end
            MUL_WR_ST: begin
                mul_a = 33'(wr_reg);
                mul_b = $signed({17'b0, step_time_reg});
            end
            MUL_W_K: begin
                mul_a = 33'(w_reg);
                mul_b = TURN_TO_BAM;
            end
            MUL_A_CX: begin
                mul_a = 33'(a_reg);
                mul_b = 33'(cx_reg);
            end
            MUL_B_CY: begin
                mul_a = 33'(b_reg);
                mul_b = 33'(cy_reg);
            end
            MUL_A_CY: begin
                mul_a = 33'(a_reg);
                mul_b = 33'(cy_reg);
            end
            MUL_B_CX: begin
                mul_a = 33'(b_reg);
                mul_b = 33'(cx_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_full = mul_a * mul_b;

    // CORDIC terms; angles in [1/4, 3/4) turn are folded by half a turn
    assign ang      = {head_reg, {(32 - ANGLE_BITS){1'b0}}};
    assign ang_flip = ang[31] ^ ang[30];
    assign xs       = cx_reg >>> it_reg;
    assign ys       = cy_reg >>> it_reg;
    assign atan_v   = atan_lut(it_reg);

    // position step: round half up by 2^38, then saturating add
    always_comb begin
        acc_rnd = acc_reg + (64'sd1 <<< 37);
        dpos    = acc_rnd[63:38];
        pos_sel = (ctrl.pos_op == POS_UPD_Y_OUT) ? pos_y_reg : pos_x_reg;
        pos_sum = SUM_W'(pos_sel) + SUM_W'(dpos);
        if (pos_sum > PMAX) begin
            pos_new = PMAX[POS_BITS-1:0];
        end else if (pos_sum < PMIN) begin
            pos_new = PMIN[POS_BITS-1:0];
        end else begin
            pos_new = pos_sum[POS_BITS-1:0];
        end
    end

    // heading increment keeps only the wrapped low bits of the rounded shift
    assign dh_rnd    = prod_reg + (64'sd1 <<< (55 - ANGLE_BITS));
    assign head_next = head_reg + dh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_time_reg <= STEP_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_STEP_TIME)) begin
            step_time_reg <= pwdata[15:0];
        end
    end

    // datapath payload
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            vx_reg <= s_vel_x;
            vy_reg <= s_vel_y;
            wr_reg <= s_yaw_rate;
        end

        if (ctrl.mul_sel != MUL_NONE) begin
            prod_reg <= prod_full[63:0];
        end

        case (ctrl.dst_sel)
            DST_A:       a_reg   <= prod_reg[31:0];
            DST_B:       b_reg   <= prod_reg[31:0];
            DST_W:       w_reg   <= prod_reg[31:0];
            DST_DH:      dh_reg  <= dh_rnd[55:56-ANGLE_BITS];
            DST_ACC_SET: acc_reg <= prod_reg;
            DST_ACC_SUB: acc_reg <= acc_reg - prod_reg;
            DST_ACC_ADD: acc_reg <= acc_reg + prod_reg;
            default: ;
        endcase

        case (ctrl.rot_op)
            ROT_INIT: begin
                cx_reg   <= CORDIC_X0;
                cy_reg   <= '0;
                cz_reg   <= $signed({ang[31] ^ ang_flip, ang[30:0]});
                flip_reg <= ang_flip;
            end
            ROT_ITER: begin
                if (!cz_reg[31]) begin
                    cx_reg <= cx_reg - ys;
                    cy_reg <= cy_reg + xs;
                    cz_reg <= cz_reg - atan_v;
                end else begin
                    cx_reg <= cx_reg + ys;
                    cy_reg <= cy_reg - xs;
                    cz_reg <= cz_reg + atan_v;
                end
            end
            ROT_FLIP: begin
                if (flip_reg) begin
                    cx_reg <= -cx_reg;
                    cy_reg <= -cy_reg;
                end
            end
            default: ;
        endcase

        if (ctrl.pos_op == POS_UPD_Y_OUT) begin
            m_pos_x_reg   <= clamp32(pos_x_reg);
            m_pos_y_reg   <= clamp32(pos_new);
            m_heading_reg <= hdg16(head_next);
        end
    end

    // pose state, iteration count and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            head_reg    <= '0;
            it_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            case (ctrl.rot_op)
                ROT_INIT: it_reg <= '0;
                ROT_ITER: it_reg <= it_reg + 1'b1;
                default: ;
            endcase

            case (ctrl.pos_op)
                POS_UPD_X: pos_x_reg <= pos_new;
                POS_UPD_Y_OUT: begin
                    pos_y_reg <= pos_new;
                    head_reg  <= head_next;
                end
                default: ;
            endcase

            if (ctrl.pos_op == POS_UPD_Y_OUT) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    `PPEI_ASSERT_NEXT(a_busy_after_in, s_valid && s_ready, !s_ready, "input taken while busy")
    `PPEI_ASSERT_SAME(a_heading_out, $rose(m_valid_reg), m_heading == hdg16(head_reg), "heading out of step with state")
    `PPEI_ASSERT_SAME(a_iter_range, 1'b1, it_reg <= ITER_W'(CORDIC_ITERS), "CORDIC iteration count overran")

endmodule

@@ design/ppei_useq.sv @@
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
// Depends on ppei_pkg for the control word, status struct and ROM.
module ppei_useq (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  ppei_pkg::useq_status_t  status,
    output ppei_pkg::ctrl_t         ctrl
);
    import ppei_pkg::*;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            jump;

    assign ctrl = ucode_rom(pc_reg);

    always_comb begin
        case (ctrl.cond)
            COND_NONE:       jump = 1'b0;
            COND_NOT_ACCEPT: jump = !status.accept;
            COND_ITER_MORE:  jump = status.iter_more;
            COND_OUT_BUSY:   jump = status.out_busy;
            COND_ALWAYS:     jump = 1'b1;
            default:         jump = 1'b1;
        endcase
        pc_next = jump ? ctrl.target : pc_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= PC_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for planar_pose_euler_integrator: velocity commands over valid/ready,
// step_time over APB, every pose checked against a fixed-point dead-reckoning predictor.
// Depends on ppei_pkg and the planar_pose_euler_integrator RTL.

module testbench;
    import ppei_pkg::*;

    localparam int         CYCLE_LIMIT  = 1_000_000;
    localparam int         DRAIN_CYCLES = 40;
    localparam int         MAX_PRINTS   = 40;
    localparam int         ROT_STEPS    = 24;
    localparam longint     ROT_GAIN_X0  = 64'sd652032874;
    // round(2^32 / (2*pi))
    localparam longint     RAD_TO_TURN  = 64'sd683565276;
    localparam longint     HALF_POS     = 64'sd1 <<< 37;
    localparam longint     HALF_TURN    = 64'sd1 <<< 39;
    localparam longint     POS_MAX      = 64'sd2147483647;
    localparam longint     POS_MIN      = -64'sd2147483648;
    localparam logic [2:0] ADDR_STEP_TIME = {REG_STEP_TIME, 2'b00};
    localparam logic [2:0] ADDR_SPARE     = 3'd4;

    typedef struct packed {
        logic [15:0] vel_x;
        logic [15:0] vel_y;
        logic [15:0] yaw_rate;
    } vel_cmd_t;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [15:0] heading;
    } pose_t;

    typedef enum int {
        MIX_UNIFORM,
        MIX_DRIVE_FWD,
        MIX_DRIVE_BACK
    } cmd_mix_t;

    logic               aclk;
    logic               aresetn = 1'b0;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [2:0]         paddr   = '0;
    logic [31:0]        pwdata  = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid    = 1'b0;
    logic               s_ready;
    logic signed [15:0] s_vel_x    = '0;
    logic signed [15:0] s_vel_y    = '0;
    logic signed [15:0] s_yaw_rate = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_pos_x;
    logic signed [31:0] m_pos_y;
    logic [15:0]        m_heading;

    vel_cmd_t    cmd_q[$];
    pose_t       pose_q[$];
    logic [15:0] step_time_cfg = STEP_RESET;
    longint      track_x       = 0;
    longint      track_y       = 0;
    logic [15:0] track_heading = '0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          error_count   = 0;
    int          accepted_count = 0;
    int          checked_count = 0;
    int          limit_count   = 0;
    int          config_count  = 0;
    int          cycle_count   = 0;

    longint arctan_step [ROT_STEPS] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304,
        652, 326, 163, 81
    };

    planar_pose_euler_integrator i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_vel_x    (s_vel_x),
        .s_vel_y    (s_vel_y),
        .s_yaw_rate (s_yaw_rate),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_pos_x    (m_pos_x),
        .m_pos_y    (m_pos_y),
        .m_heading  (m_heading)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic report_error(input string msg);
        if (error_count < MAX_PRINTS) $display("[cycle %0d] ERROR: %s", cycle_count, msg);
        error_count++;
    endtask

    // CORDIC cos/sin of the heading in Q2.30; the back half-turn is folded to the front.
    function automatic void rotate_by_heading(input logic [15:0] h, output longint cos_v,
                                              output longint sin_v);
        logic [31:0]        turn;
        logic [31:0]        shifted;
        logic signed [31:0] turn_s;
        logic               flip;
        longint             x, y, z, xs, ys;
        turn    = {h, 16'h0000};
        shifted = turn + 32'h4000_0000;
        flip    = shifted[31];
        if (flip) turn = turn - 32'h8000_0000;
        turn_s = turn;
        z = turn_s;
        x = ROT_GAIN_X0;
        y = 0;
        for (int i = 0; i < ROT_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - arctan_step[i];
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + arctan_step[i];
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        cos_v = x;
        sin_v = y;
    endfunction

    function automatic longint clamp_pos(input longint v);
        if (v > POS_MAX) return POS_MAX;
        if (v < POS_MIN) return POS_MIN;
        return v;
    endfunction

    // One Euler step: rotate by the old heading, then advance the heading.
    function automatic void integrate_step(input logic signed [15:0] vx,
                                           input logic signed [15:0] vy,
                                           input logic signed [15:0] wz);
        longint st, a, b, w, cos_v, sin_v, dx, dy, dh;
        pose_t  p;
        st = longint'(step_time_cfg);
        a  = longint'(vx) * st;
        b  = longint'(vy) * st;
        w  = longint'(wz) * st;
        rotate_by_heading(track_heading, cos_v, sin_v);
        dx = (a * cos_v - b * sin_v + HALF_POS) >>> 38;
        dy = (a * sin_v + b * cos_v + HALF_POS) >>> 38;
        track_x = clamp_pos(track_x + dx);
        track_y = clamp_pos(track_y + dy);
        dh = (w * RAD_TO_TURN + HALF_TURN) >>> 40;
        track_heading = track_heading + 16'(dh);
        p.pos_x   = 32'(track_x);
        p.pos_y   = 32'(track_y);
        p.heading = track_heading;
        pose_q.push_back(p);
    endfunction

    function automatic logic [15:0] pick_field();
        if ($urandom_range(7) != 0) return 16'($urandom);
        case ($urandom_range(4))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'h0001;
        endcase
    endfunction

    function automatic vel_cmd_t random_cmd(input cmd_mix_t mix);
        vel_cmd_t           c;
        logic signed [15:0] push;
        if (mix == MIX_UNIFORM) begin
            c.vel_x    = pick_field();
            c.vel_y    = pick_field();
            c.yaw_rate = pick_field();
        end else begin
            // near full speed in one direction, slow yaw: walks the pose into saturation
            push = 16'sd32767 - 16'($urandom_range(2000));
            if (mix == MIX_DRIVE_BACK) push = -push;
            c.vel_x    = push;
            c.vel_y    = push >>> $urandom_range(3);
            c.yaw_rate = 16'($urandom_range(64)) - 16'd32;
        end
        return c;
    endfunction

    function automatic void queue_cmd(input logic [15:0] vx, input logic [15:0] vy,
                                      input logic [15:0] wz);
        vel_cmd_t c;
        c.vel_x    = vx;
        c.vel_y    = vy;
        c.yaw_rate = wz;
        cmd_q.push_back(c);
    endfunction

    // Command driver: predicts on each accepted transfer.
    always @(posedge aclk) begin
        vel_cmd_t next_cmd;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                integrate_step(s_vel_x, s_vel_y, s_yaw_rate);
                accepted_count++;
            end
            if (!s_valid || s_ready) begin
                if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_cmd   = cmd_q.pop_front();
                    s_valid    <= 1'b1;
                    s_vel_x    <= next_cmd.vel_x;
                    s_vel_y    <= next_cmd.vel_y;
                    s_yaw_rate <= next_cmd.yaw_rate;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Pose monitor.
    always @(posedge aclk) begin
        pose_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pose_q.size() == 0) begin
                    report_error($sformatf("pose with nothing expected: x=%0d y=%0d h=%0d",
                                           m_pos_x, m_pos_y, m_heading));
                end else begin
                    want = pose_q.pop_front();
                    if (m_pos_x !== want.pos_x)
                        report_error($sformatf("pose %0d pos_x: got %0d expected %0d",
                                               checked_count, m_pos_x, $signed(want.pos_x)));
                    if (m_pos_y !== want.pos_y)
                        report_error($sformatf("pose %0d pos_y: got %0d expected %0d",
                                               checked_count, m_pos_y, $signed(want.pos_y)));
                    if (m_heading !== want.heading)
                        report_error($sformatf("pose %0d heading: got %0d expected %0d",
                                               checked_count, m_heading, want.heading));
                    if (want.pos_x == 32'h7FFF_FFFF || want.pos_x == 32'h8000_0000 ||
                        want.pos_y == 32'h7FFF_FFFF || want.pos_y == 32'h8000_0000)
                        limit_count++;
                    checked_count++;
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic wait_idle();
        do @(negedge aclk); while (cmd_q.size() != 0 || s_valid || pose_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_STEP_TIME) step_time_cfg = data[15:0];
        config_count++;
    endtask

    task automatic apb_read_check();
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_STEP_TIME;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== {16'h0000, step_time_cfg})
            report_error($sformatf("step_time readback: got %0d expected %0d",
                                   prdata, step_time_cfg));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        logic [15:0] step;
        cmd_mix_t    mix;
        int          len;
        send_idle_pct = 15;
        recv_idle_pct = 75;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // reset step_time: field extremes and sign patterns
        queue_cmd(16'h0000, 16'h0000, 16'h0000);
        queue_cmd(16'h7FFF, 16'h0000, 16'h0000);
        queue_cmd(16'h8000, 16'h0000, 16'h0000);
        queue_cmd(16'h0000, 16'h7FFF, 16'h0000);
        queue_cmd(16'h0000, 16'h8000, 16'h0000);
        queue_cmd(16'h0000, 16'h0000, 16'h7FFF);
        queue_cmd(16'h7FFF, 16'h7FFF, 16'h8000);
        queue_cmd(16'h8000, 16'h8000, 16'h7FFF);
        queue_cmd(16'h0001, 16'hFFFF, 16'h0001);
        queue_cmd(16'hFFFF, 16'h0001, 16'hFFFF);
        queue_cmd(16'h5555, 16'hAAAA, 16'h7FFF);
        queue_cmd(16'hAAAA, 16'h5555, 16'h7FFF);
        wait_idle();

        // write to an unmapped register must leave step_time alone
        apb_write(ADDR_SPARE, 32'h0000_1234);
        apb_read_check();

        // zero step: pose holds still
        apb_write(ADDR_STEP_TIME, 32'h0000_0000);
        queue_cmd(16'h7FFF, 16'h8000, 16'h7FFF);
        queue_cmd(16'h8000, 16'h7FFF, 16'h8000);
        queue_cmd(16'h1234, 16'hEDCB, 16'h4000);
        wait_idle();

        apb_write(ADDR_STEP_TIME, 32'h0000_FFFF);
        queue_cmd(16'h7FFF, 16'h7FFF, 16'h7FFF);
        queue_cmd(16'h8000, 16'h7FFF, 16'h8000);
        queue_cmd(16'h7FFF, 16'h8000, 16'h4000);
        queue_cmd(16'h0000, 16'h0000, 16'h8000);

        for (int ph = 0; ph < 9; ph++) begin
            wait_idle();
            if (ph >= 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else if (ph >= 3) begin
                send_idle_pct = 75;
                recv_idle_pct = 15;
            end
            mix = MIX_UNIFORM;
            len = 200;
            case (ph)
                0: begin
                    step = 16'd1;
                    len  = 150;
                end
                1: step = 16'hFFFF;
                3: begin
                    step = 16'hFFFF;
                    mix  = MIX_DRIVE_FWD;
                    len  = 300;
                end
                4: begin
                    step = 16'hFFFF;
                    mix  = MIX_DRIVE_BACK;
                    len  = 300;
                end
                5: step = STEP_RESET;
                6: step = 16'h8000;
                8: step = 16'hFFFF;
                default: step = 16'($urandom_range(65535, 2));
            endcase
            apb_write(ADDR_STEP_TIME, {16'h0000, step});
            apb_read_check();
            repeat (len) cmd_q.push_back(random_cmd(mix));
        end
        wait_idle();

        $display("summary: %0d velocity commands, %0d poses checked, %0d at a position limit",
                 accepted_count, checked_count, limit_count);
        $display("summary: %0d config writes incl. zero and full-scale step, three stall mixes",
                 config_count);
        if (error_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
